[sv/lcdns_pkg.sv]
package lcdns_pkg;

    // display geometry and field widths
    localparam int MAX_COLS = 40;
    localparam int COL_W    = 6;
    localparam int ROW_W    = 2;
    localparam int LINES_W  = 3;
    localparam int HOLD_W   = 10;
    localparam int WAIT_W   = 19;
    localparam int STEP_W   = 4;

    // request queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // configuration register indexes
    localparam logic [1:0] CFG_NUM_COLS     = 2'd0;
    localparam logic [1:0] CFG_NUM_LINES    = 2'd1;
    localparam logic [1:0] CFG_BYTE_HOLD_US = 2'd2;

    // fixed controller timings in microseconds
    localparam logic [WAIT_W-1:0] T_POWER_UP  = 19'd300000;
    localparam logic [WAIT_W-1:0] T_WAKE_LONG = 19'd4500;
    localparam logic [WAIT_W-1:0] T_WAKE_SHRT = 19'd150;
    localparam logic [WAIT_W-1:0] T_MODE_4BIT = 19'd500;
    localparam logic [WAIT_W-1:0] T_FSET_XTRA = 19'd3000;
    localparam logic [WAIT_W-1:0] T_CLR_XTRA  = 19'd2000;

    // command bytes
    localparam logic [7:0] CMD_FSET_BASE = 8'h20;
    localparam logic [7:0] CMD_TWO_LINE  = 8'h08;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_HOME      = 8'h02;
    localparam logic [7:0] CMD_HOME_ALT  = 8'h03;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;
    localparam logic [3:0] NIB_WAKE      = 4'h3;
    localparam logic [3:0] NIB_4BIT      = 4'h2;

    typedef enum logic [1:0]
    {
        FUNC_CHAR   = 2'd0,
        FUNC_CMD    = 2'd1,
        FUNC_CURSOR = 2'd2,
        FUNC_INIT   = 2'd3
    } func_t;

    typedef enum logic
    {
        JOB_BYTES = 1'b0,
        JOB_INIT  = 1'b1
    } job_kind_t;

    // classified request handed from front to back
    typedef struct packed
    {
        job_kind_t  kind;
        logic [7:0] byte_a;
        logic       rs_a;
        logic       has_b;
        logic [7:0] byte_b;
        logic       two_line;
    } job_t;

    // one strobe on the lcd bus
    typedef struct packed
    {
        logic              strobe;
        logic [3:0]        nibble;
        logic              rs;
        logic [WAIT_W-1:0] wait_us;
        logic              last;
    } beat_t;

    function automatic logic [6:0] row_base(input logic [ROW_W-1:0] row);
        logic [6:0] base;
        case (row)
            2'd0:    base = 7'h00;
            2'd1:    base = 7'h40;
            2'd2:    base = 7'h14;
            default: base = 7'h54;
        endcase
        return base;
    endfunction

    // set ddram address command for a cursor position
    function automatic logic [7:0] ddram_cmd(input logic [COL_W-1:0] col,
                                             input logic [ROW_W-1:0] row);
        logic [6:0] addr;
        addr = 7'({1'b0, col}) + row_base(row);
        return {1'b1, addr};
    endfunction

    // limit a requested row to the usable line count
    function automatic logic [ROW_W-1:0] clamp_row(input logic [LINES_W-1:0] row,
                                                   input logic [LINES_W-1:0] lines);
        logic [LINES_W-1:0] eff;
        logic [LINES_W-1:0] res;
        if (lines == 3'd0)
            eff = 3'd1;
        else if (lines > 3'd4)
            eff = 3'd4;
        else
            eff = lines;
        res = (row >= eff) ? eff - 3'd1 : row;
        return res[ROW_W-1:0];
    endfunction

    // power-up sequence, one beat per step; step 0 only waits, with no strobe
    function automatic beat_t init_beat(input logic [STEP_W-1:0] step,
                                        input logic              two_line,
                                        input logic [HOLD_W-1:0] hold);
        beat_t             b;
        logic [7:0]        fset;
        logic [WAIT_W-1:0] hold_w;
        fset   = CMD_FSET_BASE | (two_line ? CMD_TWO_LINE : 8'h00);
        hold_w = WAIT_W'(hold);
        b.strobe  = 1'b1;
        b.rs      = 1'b0;
        b.last    = 1'b0;
        b.nibble  = 4'h0;
        b.wait_us = '0;
        case (step)
            4'd0:
            begin
                b.strobe  = 1'b0;
                b.wait_us = T_POWER_UP;
            end
            4'd1, 4'd2:
            begin
                b.nibble  = NIB_WAKE;
                b.wait_us = T_WAKE_LONG;
            end
            4'd3:
            begin
                b.nibble  = NIB_WAKE;
                b.wait_us = T_WAKE_SHRT;
            end
            4'd4:
            begin
                b.nibble  = NIB_4BIT;
                b.wait_us = T_MODE_4BIT;
            end
            4'd5:  b.nibble = fset[7:4];
            4'd6:
            begin
                b.nibble  = fset[3:0];
                b.wait_us = hold_w + T_FSET_XTRA;
            end
            4'd7:  b.nibble = CMD_DISP_ON[7:4];
            4'd8:
            begin
                b.nibble  = CMD_DISP_ON[3:0];
                b.wait_us = hold_w;
            end
            4'd9:  b.nibble = CMD_CLEAR[7:4];
            4'd10:
            begin
                b.nibble  = CMD_CLEAR[3:0];
                b.wait_us = hold_w + T_CLR_XTRA;
            end
            4'd11: b.nibble = CMD_ENTRY[7:4];
            default:
            begin
                b.nibble  = CMD_ENTRY[3:0];
                b.wait_us = hold_w;
                b.last    = 1'b1;
            end
        endcase
        return b;
    endfunction

endpackage

[sv/char_lcd_nibble_sequencer_unit.sv]
// a taken request is written to the queue; its beats are then registered at the output
// throughput: one beat a cycle while m_tready allows; each request takes 2 beats
// (command, set cursor, character), 4 beats (character with line wrap) or 13 (power-up)
// a four-entry request queue lets the front take requests while the back end is busy
// reset: asynchronous active low; cursor at 0,0, 20 columns, 4 lines, 200 us byte hold
module char_lcd_nibble_sequencer_unit
    import lcdns_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // value[7:0], col[13:8], row[15:14]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // strobe_res[0], nibble[4:1], rs[5], wait_us[24:6], zeros
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    logic [COL_W-1:0]   num_cols_reg;
    logic [LINES_W-1:0] num_lines_reg;
    logic [HOLD_W-1:0]  byte_hold_us_reg;
    logic               q_full;
    logic               push;
    job_t               push_job;
    logic               pop;
    logic               head_valid;
    job_t               head_job;
    beat_t              beat;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg     <= 6'd20;
            num_lines_reg    <= 3'd4;
            byte_hold_us_reg <= 10'd200;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_NUM_COLS:     num_cols_reg     <= cfg_data[COL_W-1:0];
                CFG_NUM_LINES:    num_lines_reg    <= cfg_data[LINES_W-1:0];
                CFG_BYTE_HOLD_US: byte_hold_us_reg <= cfg_data[HOLD_W-1:0];
                default:          ;
            endcase
        end
    end

    lcdns_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .q_full    (q_full),
        .func      (func_t'(s_tuser)),
        .value     (s_tdata[7:0]),
        .col       (s_tdata[13:8]),
        .row       (s_tdata[15:14]),
        .num_cols  (num_cols_reg),
        .num_lines (num_lines_reg),
        .in_ready  (s_tready),
        .push      (push),
        .job       (push_job)
    );

    lcdns_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    lcdns_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_job     (head_job),
        .byte_hold_us (byte_hold_us_reg),
        .out_ready    (m_tready),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_beat     (beat)
    );

    // master side packing
    assign m_tdata = {7'b0, beat.wait_us, beat.rs, beat.nibble, beat.strobe};
    assign m_tlast = beat.last;

endmodule

[sv/lcdns_front.sv]
module lcdns_front
    import lcdns_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               q_full,
    input  func_t              func,
    input  logic [7:0]         value,
    input  logic [COL_W-1:0]   col,
    input  logic [ROW_W-1:0]   row,
    input  logic [COL_W-1:0]   num_cols,
    input  logic [LINES_W-1:0] num_lines,
    output logic               in_ready,
    output logic               push,
    output job_t               job
);

    logic [COL_W-1:0] cursor_col_reg, cursor_col_next;
    logic [ROW_W-1:0] cursor_row_reg, cursor_row_next;
    logic [COL_W-1:0] cols_eff;
    logic [COL_W:0]   col_inc;
    logic             wrap;
    logic [ROW_W-1:0] wrap_row;
    logic [ROW_W-1:0] set_row;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    // cursor wrap and row clamp
    assign cols_eff = (num_cols > COL_W'(MAX_COLS)) ? COL_W'(MAX_COLS) : num_cols;
    assign col_inc  = {1'b0, cursor_col_reg} + 7'd1;
    assign wrap     = col_inc >= {1'b0, cols_eff};
    assign wrap_row = clamp_row(LINES_W'(cursor_row_reg) + 3'd1, num_lines);
    assign set_row  = clamp_row(LINES_W'(row), num_lines);

    // classify request into a job and the next cursor
    always_comb
    begin
        job.kind        = JOB_BYTES;
        job.byte_a      = value;
        job.rs_a        = 1'b0;
        job.has_b       = 1'b0;
        job.byte_b      = ddram_cmd('0, wrap_row);
        job.two_line    = num_lines > 3'd1;
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        case (func)
            FUNC_CHAR:
            begin
                job.rs_a  = 1'b1;
                job.has_b = wrap;
                if (wrap)
                begin
                    cursor_col_next = '0;
                    cursor_row_next = wrap_row;
                end
                else
                begin
                    cursor_col_next = col_inc[COL_W-1:0];
                end
            end
            FUNC_CMD:
            begin
                if (value inside {CMD_CLEAR, CMD_HOME, CMD_HOME_ALT})
                begin
                    cursor_col_next = '0;
                    cursor_row_next = '0;
                end
            end
            FUNC_CURSOR:
            begin
                job.byte_a      = ddram_cmd(col, set_row);
                cursor_col_next = col;
                cursor_row_next = set_row;
            end
            default:
            begin
                job.kind        = JOB_INIT;
                cursor_col_next = '0;
                cursor_row_next = '0;
            end
        endcase
    end

    // tracked cursor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
        end
        else if (push)
        begin
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
        end
    end

endmodule

[sv/lcdns_queue.sv]
module lcdns_queue
    import lcdns_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output job_t head_job
);

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full       = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = slot_reg[rd_ptr_reg];

    // job storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

[sv/lcdns_back.sv]
module lcdns_back
    import lcdns_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  job_t              head_job,
    input  logic [HOLD_W-1:0] byte_hold_us,
    input  logic              out_ready,
    output logic              pop,
    output logic              out_valid,
    output beat_t             out_beat
);

    logic [STEP_W-1:0] step_reg;
    logic              out_valid_reg;
    beat_t             beat_reg;
    beat_t             byte_beat;
    beat_t             beat;
    logic [7:0]        cur_byte;
    logic              advance;

    assign out_valid = out_valid_reg;
    assign out_beat  = beat_reg;
    assign advance   = head_valid && (!out_valid_reg || out_ready);
    assign pop       = advance && beat.last;

    // byte jobs: step bit 1 picks the byte, bit 0 the nibble
    always_comb
    begin
        cur_byte          = step_reg[1] ? head_job.byte_b : head_job.byte_a;
        byte_beat.strobe  = 1'b1;
        byte_beat.rs      = step_reg[1] ? 1'b0 : head_job.rs_a;
        byte_beat.nibble  = step_reg[0] ? cur_byte[3:0] : cur_byte[7:4];
        byte_beat.wait_us = step_reg[0] ? WAIT_W'(byte_hold_us) : '0;
        byte_beat.last    = step_reg[0] && (step_reg[1] || !head_job.has_b);
    end

    assign beat = (head_job.kind == JOB_INIT)
                  ? init_beat(step_reg, head_job.two_line, byte_hold_us)
                  : byte_beat;

    // step counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                step_reg <= beat.last ? '0 : step_reg + 1'b1;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // output beat register
    always_ff @(posedge clk)
    begin
        if (advance)
            beat_reg <= beat;
    end

endmodule

[bench/tb_char_lcd_nibble_sequencer_unit.sv]
module tb_char_lcd_nibble_sequencer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import lcdns_pkg::*;

    // one request as the sender sees it
    typedef struct
    {
        func_t      func;
        logic [7:0] value;
        logic [5:0] col;
        logic [1:0] row;
    } lcd_req_t;

    localparam logic [6:0] ROW_OFFSET [4] = '{7'h00, 7'h40, 7'h14, 7'h54};
    localparam int LONG_STALL_CYCLES = 400;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;   // value[7:0], col[13:8], row[15:14]
    logic [1:0]  s_tuser   = '0;   // func[1:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // strobe_res[0], nibble[4:1], rs[5], wait_us[24:6], zeros
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [9:0]  cfg_data  = '0;

    // register copies and tracked cursor of the predictor
    logic [5:0]  cfg_cols  = 6'd20;
    logic [2:0]  cfg_lines = 3'd4;
    logic [9:0]  cfg_hold  = 10'd200;
    logic [5:0]  cur_col   = '0;
    logic [1:0]  cur_row   = '0;

    lcd_req_t    pending_reqs [$];
    lcd_req_t    offered_req;
    beat_t       strobe_queue [$];

    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;
    int          stall_requests = 0;
    int          stall_served   = 0;
    int          stall_left     = 0;
    int          mismatches     = 0;

    char_lcd_nibble_sequencer_unit i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // strobe expansion of the lcd bus
    task automatic add_strobe(input logic strobe, input logic [3:0] nib, input logic rs,
                              input logic [WAIT_W-1:0] wait_us);
        beat_t b;
        b.strobe  = strobe;
        b.nibble  = nib;
        b.rs      = rs;
        b.wait_us = wait_us;
        b.last    = 1'b0;
        strobe_queue.push_back(b);
    endtask

    // high nibble then low nibble, hold time after the second
    task automatic add_byte(input logic [7:0] byte_val, input logic rs,
                            input logic [WAIT_W-1:0] extra);
        add_strobe(1'b1, byte_val[7:4], rs, '0);
        add_strobe(1'b1, byte_val[3:0], rs, WAIT_W'(cfg_hold) + extra);
    endtask

    // clamp row, update tracked cursor, send set ddram address
    task automatic add_cursor_move(input int unsigned col, input int unsigned row);
        int unsigned lines;
        int unsigned r;
        int unsigned c;
        logic [6:0]  addr;
        lines = (cfg_lines == 3'd0) ? 1 : ((cfg_lines > 3'd4) ? 4 : cfg_lines);
        r = (row >= lines) ? lines - 1 : row;
        c = col & 63;
        cur_col = c[5:0];
        cur_row = r[1:0];
        addr = 7'((c + ROW_OFFSET[r]) & 127);
        add_byte({1'b1, addr}, 1'b0, '0);
    endtask

    // expected strobes for one accepted request
    task automatic predict_strobes(input lcd_req_t req);
        int unsigned cols;
        int unsigned next_col;
        logic [7:0]  fset;
        beat_t       tail;
        case (req.func)
            FUNC_CHAR:
            begin
                cols = (cfg_cols > MAX_COLS) ? MAX_COLS : cfg_cols;
                add_byte(req.value, 1'b1, '0);
                next_col = cur_col + 1;
                if (next_col >= cols)
                    add_cursor_move(0, cur_row + 1);
                else
                    cur_col = next_col[5:0];
            end
            FUNC_CMD:
            begin
                add_byte(req.value, 1'b0, '0);
                if (req.value inside {CMD_CLEAR, CMD_HOME, CMD_HOME_ALT})
                begin
                    cur_col = '0;
                    cur_row = '0;
                end
            end
            FUNC_CURSOR:
            begin
                add_cursor_move(req.col, req.row);
            end
            default:
            begin
                fset = CMD_FSET_BASE | ((cfg_lines > 3'd1) ? CMD_TWO_LINE : 8'h00);
                add_strobe(1'b0, 4'h0, 1'b0, T_POWER_UP);
                add_strobe(1'b1, NIB_WAKE, 1'b0, T_WAKE_LONG);
                add_strobe(1'b1, NIB_WAKE, 1'b0, T_WAKE_LONG);
                add_strobe(1'b1, NIB_WAKE, 1'b0, T_WAKE_SHRT);
                add_strobe(1'b1, NIB_4BIT, 1'b0, T_MODE_4BIT);
                add_byte(fset, 1'b0, T_FSET_XTRA);
                add_byte(CMD_DISP_ON, 1'b0, '0);
                add_byte(CMD_CLEAR, 1'b0, T_CLR_XTRA);
                add_byte(CMD_ENTRY, 1'b0, '0);
                cur_col = '0;
                cur_row = '0;
            end
        endcase
        tail = strobe_queue.pop_back();
        tail.last = 1'b1;
        strobe_queue.push_back(tail);
    endtask

    // sender: offers queued requests, holds each until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_strobes(offered_req);
            if (!(s_tvalid && !s_tready))
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered_req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {offered_req.row, offered_req.col, offered_req.value};
                    s_tuser  <= offered_req.func;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    // receiver: checks every beat, stalls at random or for a long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        beat_t exp_beat;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (strobe_queue.size() == 0)
                begin
                    $error("beat with no expected strobe: tdata %h last %b", m_tdata, m_tlast);
                    mismatches++;
                end
                else
                begin
                    exp_beat = strobe_queue.pop_front();
                    check_field("strobe_res", exp_beat.strobe, m_tdata[0]);
                    check_field("nibble", exp_beat.nibble, m_tdata[4:1]);
                    check_field("rs", exp_beat.rs, m_tdata[5]);
                    check_field("wait_us", exp_beat.wait_us, m_tdata[24:6]);
                    check_field("last", exp_beat.last, m_tlast);
                end
            end
            if (stall_served != stall_requests)
            begin
                stall_served++;
                stall_left = LONG_STALL_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic wait_drained();
        @(negedge clk);
        while (pending_reqs.size() != 0 || s_tvalid || strobe_queue.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_NUM_COLS:  cfg_cols  = val[5:0];
            CFG_NUM_LINES: cfg_lines = val[2:0];
            default:       cfg_hold  = val;
        endcase
    endtask

    task automatic set_geometry(input int unsigned cols, input int unsigned lines,
                                input int unsigned hold);
        wait_drained();
        write_reg(CFG_NUM_COLS, 10'(cols));
        write_reg(CFG_NUM_LINES, 10'(lines));
        write_reg(CFG_BYTE_HOLD_US, 10'(hold));
    endtask

    task automatic queue_req(input func_t func, input logic [7:0] value,
                             input logic [5:0] col, input logic [1:0] row);
        lcd_req_t r;
        r.func  = func;
        r.value = value;
        r.col   = col;
        r.row   = row;
        pending_reqs.push_back(r);
    endtask

    // mostly characters and cursor moves, commands (some clear/home) and power-up mixed in
    task automatic queue_random_reqs(input int count);
        int unsigned pick;
        logic [7:0]  value;
        func_t       func;
        repeat (count)
        begin
            pick  = $urandom_range(99);
            value = 8'($urandom_range(255));
            if (pick < 50)
                func = FUNC_CHAR;
            else if (pick < 70)
            begin
                func = FUNC_CMD;
                if ($urandom_range(2) == 0)
                    value = 8'($urandom_range(3));
            end
            else if (pick < 92)
                func = FUNC_CURSOR;
            else
                func = FUNC_INIT;
            queue_req(func, value, 6'($urandom_range(63)), 2'($urandom_range(3)));
        end
    endtask

    task automatic run_phase(input int unsigned cols, input int unsigned lines,
                             input int unsigned hold, input int send_pct, input int recv_pct,
                             input bit long_stall, input int count);
        set_geometry(cols, lines, hold);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        if (long_stall)
            stall_requests++;
        queue_random_reqs(count);
    endtask

    // main sequence
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed, reset geometry: power-up, byte extremes, clear and home
        queue_req(FUNC_INIT, 8'h00, 6'd0, 2'd0);
        queue_req(FUNC_CHAR, 8'h00, 6'd0, 2'd0);
        queue_req(FUNC_CHAR, 8'hFF, 6'd63, 2'd3);
        queue_req(FUNC_CMD, CMD_CLEAR, 6'd0, 2'd0);
        queue_req(FUNC_CHAR, 8'h55, 6'd0, 2'd0);
        queue_req(FUNC_CMD, CMD_HOME, 6'd0, 2'd0);
        queue_req(FUNC_CHAR, 8'hAA, 6'd0, 2'd0);
        queue_req(FUNC_CMD, CMD_HOME_ALT, 6'd0, 2'd0);
        queue_req(FUNC_CMD, 8'h00, 6'd0, 2'd0);
        queue_req(FUNC_CHAR, 8'h41, 6'd0, 2'd0);
        queue_req(FUNC_CMD, 8'hFF, 6'd0, 2'd0);
        queue_req(FUNC_CHAR, 8'h42, 6'd0, 2'd0);
        // address overflow at the far corner, then a wrap clamped to the last row
        queue_req(FUNC_CURSOR, 8'h00, 6'd63, 2'd3);
        queue_req(FUNC_CHAR, 8'h43, 6'd0, 2'd0);
        queue_req(FUNC_CURSOR, 8'hFF, 6'd0, 2'd0);
        queue_req(FUNC_CURSOR, 8'h00, 6'd19, 2'd2);
        queue_req(FUNC_CHAR, 8'h44, 6'd0, 2'd0);

        // directed, narrow two-line display: row clamp and wrap at the bottom
        set_geometry(2, 2, 0);
        queue_req(FUNC_CURSOR, 8'h00, 6'd5, 2'd3);
        queue_req(FUNC_CHAR, 8'h30, 6'd0, 2'd0);
        queue_req(FUNC_CHAR, 8'h31, 6'd0, 2'd0);
        queue_req(FUNC_CHAR, 8'h32, 6'd0, 2'd0);
        queue_req(FUNC_INIT, 8'h00, 6'd0, 2'd0);
        queue_req(FUNC_CHAR, 8'h33, 6'd0, 2'd0);
        queue_req(FUNC_CHAR, 8'h34, 6'd0, 2'd0);

        // random phases across geometries and idling patterns
        run_phase(40, 4, 1000, 0, 0, 0, 60);
        run_phase(1, 1, 0, 83, 0, 0, 60);
        run_phase(63, 7, 1023, 0, 83, 0, 60);
        run_phase(0, 0, 517, 14, 14, 0, 60);
        run_phase($urandom_range(63), $urandom_range(7), $urandom_range(1023), 0, 0, 1, 60);
        run_phase(8, 3, 200, 83, 0, 0, 60);
        run_phase(20, 5, 1, 0, 83, 0, 60);

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && strobe_queue.size() == 0)
            $display("[char_lcd_nibble_sequencer_unit] OK");
        else
            $display("[char_lcd_nibble_sequencer_unit] ERROR");
        $finish;
    end

    // run time limit
    initial
    begin
        #4ms;
        $display("[char_lcd_nibble_sequencer_unit] ERROR");
        $finish;
    end

endmodule

[files.f]
sv/lcdns_pkg.sv
sv/lcdns_front.sv
sv/lcdns_queue.sv
sv/lcdns_back.sv
sv/char_lcd_nibble_sequencer_unit.sv
bench/tb_char_lcd_nibble_sequencer_unit.sv
